FILE: rtl/trq_pkg.sv
// trq_pkg: shared types and constants of the tcp retransmit queue
// no dependencies; used by the interfaces, all rtl modules and the checker
package trq_pkg;

	localparam int SEQ_W    = 32;
	localparam int LEN_W    = 16;
	localparam int HANDLE_W = 16;
	localparam int CNT_W    = 5;

	// request kinds
	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_ACK  = 1'b1
	} cmd_kind_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_PUSHED      = 3'd0,
		ST_FULL        = 3'd1,
		ST_NONCONTIG   = 3'd2,
		ST_ACK_OK      = 3'd3,
		ST_ACK_AT_HEAD = 3'd4,
		ST_OLD_ACK     = 3'd5,
		ST_EMPTY       = 3'd6
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK
	} state_t;

	// one queued segment
	typedef struct packed {
		logic [SEQ_W-1:0]    start_seq;
		logic [SEQ_W-1:0]    end_seq;
		logic [LEN_W-1:0]    payload_len;
		logic [HANDLE_W-1:0] buf_handle;
	} entry_t;

	// controller to datapath commands
	typedef struct packed {
		logic    capture;
		logic    push;
		logic    set_status;
		status_t status;
		logic    rd;
		logic    pop;
		logic    timer_off;
		logic    finish;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic full;
		logic noncontig;
		logic empty;
		logic old_ack;
		logic at_head;
		logic pop_ok;
		logic is_ack;
	} sts_t;

endpackage

FILE: rtl/trq_if.sv
// trq_req_if / trq_rsp_if: valid-ready channels of the retransmit queue
// depends on trq_pkg for field widths
interface trq_req_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [trq_pkg::SEQ_W-1:0]    seg_start;
	logic [trq_pkg::SEQ_W-1:0]    seg_end;
	logic [trq_pkg::LEN_W-1:0]    seg_data_len;
	logic [trq_pkg::HANDLE_W-1:0] buffer_handle;
	logic [trq_pkg::SEQ_W-1:0]    ack_value;

	modport source (output valid, command, seg_start, seg_end, seg_data_len,
		buffer_handle, ack_value, input ready);
	modport sink (input valid, command, seg_start, seg_end, seg_data_len,
		buffer_handle, ack_value, output ready);
endinterface

interface trq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    status;
	logic [trq_pkg::CNT_W-1:0]    released_count;
	logic [trq_pkg::SEQ_W-1:0]    in_flight_bytes;
	logic                          timer_running;
	logic                          timer_started;
	logic                          head_valid;
	logic [trq_pkg::LEN_W-1:0]    head_len;
	logic [trq_pkg::HANDLE_W-1:0] head_buffer;
	logic [trq_pkg::CNT_W-1:0]    entry_count;

	modport source (output valid, status, released_count, in_flight_bytes,
		timer_running, timer_started, head_valid, head_len, head_buffer,
		entry_count, input ready);
	modport sink (input valid, status, released_count, in_flight_bytes,
		timer_running, timer_started, head_valid, head_len, head_buffer,
		entry_count, output ready);
endinterface

FILE: rtl/trq_datapath.sv
// trq_datapath: segment ring memory, pointers, byte and timer state, result register
// depends on trq_pkg; driven by trq_ctrl through ctl_t
module trq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  trq_pkg::ctl_t                 ctl,
	output trq_pkg::sts_t                 sts,
	input  logic                          command,
	input  logic [trq_pkg::SEQ_W-1:0]    seg_start,
	input  logic [trq_pkg::SEQ_W-1:0]    seg_end,
	input  logic [trq_pkg::LEN_W-1:0]    seg_data_len,
	input  logic [trq_pkg::HANDLE_W-1:0] buffer_handle,
	input  logic [trq_pkg::SEQ_W-1:0]    ack_value,
	output logic [2:0]                    status,
	output logic [trq_pkg::CNT_W-1:0]    released_count,
	output logic [trq_pkg::SEQ_W-1:0]    in_flight_bytes,
	output logic                          timer_running,
	output logic                          timer_started,
	output logic                          head_valid,
	output logic [trq_pkg::LEN_W-1:0]    head_len,
	output logic [trq_pkg::HANDLE_W-1:0] head_buffer,
	output logic [trq_pkg::CNT_W-1:0]    entry_count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	trq_pkg::entry_t mem [DEPTH];
	trq_pkg::entry_t rd_q;

	logic [AW-1:0]               head_q, tail_q;
	logic [CW-1:0]               count_q, released_q;
	logic [trq_pkg::SEQ_W-1:0]  bytes_q, last_end_q, ack_q;
	logic                        timer_q, started_q, is_ack_q;
	trq_pkg::status_t            status_q, status_nxt;
	logic                        timer_nxt;
	logic [CW+trq_pkg::CNT_W-1:0] count_ext, released_ext;
	trq_pkg::entry_t             wr_entry;

	// flags for the controller
	assign sts.full      = (count_q == FULL_CNT);
	assign sts.noncontig = (count_q != '0) && (last_end_q != seg_start);
	assign sts.empty     = (count_q == '0);
	assign sts.old_ack   = (rd_q.start_seq > ack_q);
	assign sts.at_head   = (rd_q.start_seq == ack_q);
	assign sts.pop_ok    = (count_q != '0) && (rd_q.end_seq <= ack_q);
	assign sts.is_ack    = is_ack_q;

	assign wr_entry = '{start_seq: seg_start, end_seq: seg_end,
		payload_len: seg_data_len, buf_handle: buffer_handle};

	// segment ring write
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= wr_entry;
		end
	end

	// registered head read
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_q <= mem[head_q];
		end
	end

	// per-request operands
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			ack_q <= ack_value;
		end
	end

	assign status_nxt = ctl.set_status ? ctl.status : status_q;
	assign timer_nxt  = ctl.timer_off ? 1'b0 : timer_q;

	// queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			bytes_q    <= '0;
			timer_q    <= 1'b0;
			started_q  <= 1'b0;
			released_q <= '0;
			is_ack_q   <= 1'b0;
			status_q   <= trq_pkg::ST_PUSHED;
			last_end_q <= '0;
		end else begin
			// an accepted push starts a stopped timer
			if (ctl.capture) begin
				is_ack_q   <= (command == trq_pkg::CMD_ACK);
				started_q  <= ctl.push && !timer_q;
				released_q <= '0;
			end
			if (ctl.set_status) begin
				status_q <= ctl.status;
			end
			if (ctl.push) begin
				tail_q     <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
				count_q    <= count_q + 1'b1;
				bytes_q    <= bytes_q + (seg_end - seg_start);
				last_end_q <= seg_end;
				timer_q    <= 1'b1;
			end
			if (ctl.pop) begin
				head_q     <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
				count_q    <= count_q - 1'b1;
				bytes_q    <= bytes_q - (rd_q.end_seq - rd_q.start_seq);
				released_q <= released_q + 1'b1;
			end
			if (ctl.timer_off) begin
				timer_q <= 1'b0;
			end
		end
	end

	assign count_ext    = {{trq_pkg::CNT_W{1'b0}}, count_q};
	assign released_ext = {{trq_pkg::CNT_W{1'b0}}, released_q};

	// result register
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			status          <= status_nxt;
			released_count  <= released_ext[trq_pkg::CNT_W-1:0];
			in_flight_bytes <= bytes_q;
			timer_running   <= timer_nxt;
			timer_started   <= started_q;
			head_valid      <= (count_q != '0);
			head_len        <= (count_q != '0) ? rd_q.payload_len : '0;
			head_buffer     <= (count_q != '0) ? rd_q.buf_handle : '0;
			entry_count     <= count_ext[trq_pkg::CNT_W-1:0];
		end
	end

endmodule

FILE: rtl/trq_ctrl.sv
// trq_ctrl: request sequencer of the retransmit queue and result valid flag
// depends on trq_pkg; drives trq_datapath through ctl_t
module trq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_command,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  trq_pkg::sts_t  sts,
	output trq_pkg::ctl_t  ctl
);
	trq_pkg::state_t state_q, state_nxt;
	logic            first_q, rsp_valid_q, out_free, done;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	// state register and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trq_pkg::S_IDLE;
			first_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.capture) begin
				first_q <= 1'b1;
			end else if (state_q == trq_pkg::S_CHECK && state_nxt != trq_pkg::S_CHECK) begin
				first_q <= 1'b0;
			end
			if (ctl.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		done      = 1'b0;
		case (state_q)
			trq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.capture = 1'b1;
					state_nxt   = trq_pkg::S_READ;
					if (req_command == trq_pkg::CMD_PUSH) begin
						ctl.set_status = 1'b1;
						if (sts.full) begin
							ctl.status = trq_pkg::ST_FULL;
						end else if (sts.noncontig) begin
							ctl.status = trq_pkg::ST_NONCONTIG;
						end else begin
							ctl.status = trq_pkg::ST_PUSHED;
							ctl.push   = 1'b1;
						end
					end
				end
			end
			trq_pkg::S_READ: begin
				ctl.rd    = 1'b1;
				state_nxt = trq_pkg::S_CHECK;
			end
			trq_pkg::S_CHECK: begin
				if (!sts.is_ack) begin
					done = 1'b1;
				end else if (first_q && sts.empty) begin
					ctl.set_status = 1'b1;
					ctl.status     = trq_pkg::ST_EMPTY;
					done           = 1'b1;
				end else if (first_q && sts.old_ack) begin
					ctl.set_status = 1'b1;
					ctl.status     = trq_pkg::ST_OLD_ACK;
					done           = 1'b1;
				end else begin
					// classify on the first look, then release one head entry per pass
					if (first_q) begin
						ctl.set_status = 1'b1;
						ctl.status     = sts.at_head ? trq_pkg::ST_ACK_AT_HEAD
							: trq_pkg::ST_ACK_OK;
					end
					if (sts.pop_ok) begin
						ctl.pop   = 1'b1;
						state_nxt = trq_pkg::S_READ;
					end else begin
						done = 1'b1;
					end
				end
				// commit the result once the output register is free
				if (done && out_free) begin
					ctl.finish    = 1'b1;
					ctl.timer_off = sts.is_ack && !first_q && sts.empty;
					state_nxt     = trq_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = trq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/tcp_retransmit_queue.sv
// a push or rejected request is accepted in S_IDLE, then S_READ and S_CHECK give its result;
// an ack repeats S_READ and S_CHECK for each released entry (up to DEPTH of them), since each
// release is one registered read of the segment ring memory plus one compare
// requests are taken only in S_IDLE, once the last result is committed; a stalled result waits
// arst_n clears pointers, count, bytes in flight and timer; ring contents are not reset
// tcp_retransmit_queue: top level, joins trq_ctrl and trq_datapath; depends on trq_pkg, trq_if
module tcp_retransmit_queue #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	trq_req_if.sink     req,
	trq_rsp_if.source   rsp
);
	trq_pkg::ctl_t ctl;
	trq_pkg::sts_t sts;

	// sequencer
	trq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.sts         (sts),
		.ctl         (ctl)
	);

	// queue storage and arithmetic
	trq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.command         (req.command),
		.seg_start       (req.seg_start),
		.seg_end         (req.seg_end),
		.seg_data_len    (req.seg_data_len),
		.buffer_handle   (req.buffer_handle),
		.ack_value       (req.ack_value),
		.status          (rsp.status),
		.released_count  (rsp.released_count),
		.in_flight_bytes (rsp.in_flight_bytes),
		.timer_running   (rsp.timer_running),
		.timer_started   (rsp.timer_started),
		.head_valid      (rsp.head_valid),
		.head_len        (rsp.head_len),
		.head_buffer     (rsp.head_buffer),
		.entry_count     (rsp.entry_count)
	);

endmodule

FILE: rtl/trq_checker.sv
// trq_checker: port-level assertions for tcp_retransmit_queue, attached by bind
// depends on trq_pkg
module trq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [2:0]                    status,
	input logic [trq_pkg::CNT_W-1:0]    released_count,
	input logic                          timer_running,
	input logic                          head_valid,
	input logic [trq_pkg::LEN_W-1:0]    head_len,
	input logic [trq_pkg::HANDLE_W-1:0] head_buffer,
	input logic [trq_pkg::CNT_W-1:0]    entry_count
);
	// a held result keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
			&& $stable(entry_count) && $stable(head_len))
		else $error("result changed while stalled");

	// one request at a time: busy right after an accepted request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in work");

	// an empty queue reports no head
	a_no_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !head_valid |-> entry_count == '0 && head_len == '0
			&& head_buffer == '0)
		else $error("head fields set on empty queue");

	// an accepted push leaves the timer running
	a_push_timer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == trq_pkg::ST_PUSHED |-> timer_running && head_valid)
		else $error("push result without running timer");

	// an ack on an empty queue releases nothing
	a_empty_ack: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == trq_pkg::ST_EMPTY |-> released_count == '0 && !head_valid)
		else $error("empty ack released entries");

endmodule

bind tcp_retransmit_queue trq_checker u_trq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.released_count (rsp.released_count),
	.timer_running  (rsp.timer_running),
	.head_valid     (rsp.head_valid),
	.head_len       (rsp.head_len),
	.head_buffer    (rsp.head_buffer),
	.entry_count    (rsp.entry_count)
);

FILE: test/tb_tcp_retransmit_queue.sv
`timescale 1ns / 100ps
// tb_tcp_retransmit_queue: self-checking bench for the tcp retransmit queue
// drives push and ack requests through trq_req_if and checks every result on trq_rsp_if
// depends on trq_pkg, trq_if and the tcp_retransmit_queue rtl
module tb_tcp_retransmit_queue;

	localparam int QDEPTH = 16;
	localparam int RANDOM_REQS = 950;
	localparam int SHOWN_ERRORS = 10;

	typedef struct packed {
		trq_pkg::cmd_kind_t           command;
		logic [trq_pkg::SEQ_W-1:0]    seg_start;
		logic [trq_pkg::SEQ_W-1:0]    seg_end;
		logic [trq_pkg::LEN_W-1:0]    seg_data_len;
		logic [trq_pkg::HANDLE_W-1:0] buffer_handle;
		logic [trq_pkg::SEQ_W-1:0]    ack_value;
	} seg_req_t;

	typedef struct packed {
		trq_pkg::status_t             status;
		logic [trq_pkg::CNT_W-1:0]    released;
		logic [trq_pkg::SEQ_W-1:0]    in_flight;
		logic                         timer_running;
		logic                         timer_started;
		logic                         head_valid;
		logic [trq_pkg::LEN_W-1:0]    head_len;
		logic [trq_pkg::HANDLE_W-1:0] head_buffer;
		logic [trq_pkg::CNT_W-1:0]    entry_count;
	} queue_rsp_t;

	// one directed stimulus line; reps > 1 repeats a push as a contiguous chain
	typedef struct {
		seg_req_t    rq;
		int unsigned reps;
		bit          typed;
		queue_rsp_t  want;
	} plan_row_t;

	localparam queue_rsp_t NO_CHECK = '0;
	localparam queue_rsp_t EMPTY_RSP = '{trq_pkg::ST_EMPTY, 5'd0, 32'd0, 1'b0, 1'b0, 1'b0,
		16'h0000, 16'h0000, 5'd0};
	localparam queue_rsp_t FULL_RSP = '{trq_pkg::ST_FULL, 5'd0, 32'h0000_1000, 1'b1, 1'b0,
		1'b1, 16'h0100, 16'h0100, 5'd16};

	logic clk;
	logic arst_n;

	trq_req_if req_ch();
	trq_rsp_if rsp_ch();

	tcp_retransmit_queue #(
		.DEPTH(QDEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the segment ring
	logic [trq_pkg::SEQ_W-1:0]    sq_start  [QDEPTH];
	logic [trq_pkg::SEQ_W-1:0]    sq_end    [QDEPTH];
	logic [trq_pkg::LEN_W-1:0]    sq_len    [QDEPTH];
	logic [trq_pkg::HANDLE_W-1:0] sq_handle [QDEPTH];
	int unsigned                  rd_idx;
	int unsigned                  wr_idx;
	int unsigned                  used;
	logic [trq_pkg::SEQ_W-1:0]    flight;
	logic                         rtx_on;

	queue_rsp_t pending_reports[$];
	bit         calm;
	int         mismatches;
	int         results_seen;
	int         push_reqs;
	int         ack_reqs;
	int         status_hits [8];
	int         widest_release;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// expected result of one request; advances the shadow queue
	function automatic queue_rsp_t next_queue_report(seg_req_t rq);
		queue_rsp_t  rs;
		int unsigned h;
		rs = '0;
		h = rd_idx;
		if (rq.command == trq_pkg::CMD_PUSH) begin
			if (used >= QDEPTH) begin
				rs.status = trq_pkg::ST_FULL;
			end else if (used > 0 && sq_end[(wr_idx + QDEPTH - 1) % QDEPTH] != rq.seg_start) begin
				rs.status = trq_pkg::ST_NONCONTIG;
			end else begin
				sq_start[wr_idx] = rq.seg_start;
				sq_end[wr_idx] = rq.seg_end;
				sq_len[wr_idx] = rq.seg_data_len;
				sq_handle[wr_idx] = rq.buffer_handle;
				wr_idx = (wr_idx + 1) % QDEPTH;
				used++;
				flight = flight + (rq.seg_end - rq.seg_start);
				if (!rtx_on) begin
					rtx_on = 1'b1;
					rs.timer_started = 1'b1;
				end
				rs.status = trq_pkg::ST_PUSHED;
			end
		end else begin
			if (used == 0) begin
				rs.status = trq_pkg::ST_EMPTY;
			end else if (sq_start[h] > rq.ack_value) begin
				rs.status = trq_pkg::ST_OLD_ACK;
			end else begin
				rs.status = (sq_start[h] == rq.ack_value) ? trq_pkg::ST_ACK_AT_HEAD
					: trq_pkg::ST_ACK_OK;
				// release every head segment covered by the ack
				while (used > 0 && sq_end[h] <= rq.ack_value) begin
					flight = flight - (sq_end[h] - sq_start[h]);
					h = (h + 1) % QDEPTH;
					used--;
					rs.released++;
				end
				rd_idx = h;
				if (used == 0)
					rtx_on = 1'b0;
			end
		end
		rs.in_flight = flight;
		rs.timer_running = rtx_on;
		rs.head_valid = (used > 0);
		rs.head_len = (used > 0) ? sq_len[rd_idx] : '0;
		rs.head_buffer = (used > 0) ? sq_handle[rd_idx] : '0;
		rs.entry_count = used[trq_pkg::CNT_W-1:0];
		return rs;
	endfunction

	function automatic string report_text(queue_rsp_t r);
		return $sformatf("st=%0d rel=%0d fly=%h tmr=%b start=%b hv=%b len=%h hnd=%h cnt=%0d",
			r.status, r.released, r.in_flight, r.timer_running, r.timer_started,
			r.head_valid, r.head_len, r.head_buffer, r.entry_count);
	endfunction

	// hand one request to the block, predict it at acceptance
	task automatic issue(input seg_req_t rq, input bit typed, input queue_rsp_t want);
		queue_rsp_t rs;
		while (!calm && $urandom_range(0, 99) < 20) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= rq.command;
		req_ch.seg_start <= rq.seg_start;
		req_ch.seg_end <= rq.seg_end;
		req_ch.seg_data_len <= rq.seg_data_len;
		req_ch.buffer_handle <= rq.buffer_handle;
		req_ch.ack_value <= rq.ack_value;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		rs = next_queue_report(rq);
		if (rq.command == trq_pkg::CMD_PUSH)
			push_reqs++;
		else
			ack_reqs++;
		status_hits[rs.status]++;
		if (rs.released > widest_release)
			widest_release = rs.released;
		pending_reports.push_back(typed ? want : rs);
	endtask

	// compare one accepted result against the oldest expectation
	task automatic check_report();
		queue_rsp_t got;
		queue_rsp_t want;
		bit         bad;
		got.status = trq_pkg::status_t'(rsp_ch.status);
		got.released = rsp_ch.released_count;
		got.in_flight = rsp_ch.in_flight_bytes;
		got.timer_running = rsp_ch.timer_running;
		got.timer_started = rsp_ch.timer_started;
		got.head_valid = rsp_ch.head_valid;
		got.head_len = rsp_ch.head_len;
		got.head_buffer = rsp_ch.head_buffer;
		got.entry_count = rsp_ch.entry_count;
		results_seen++;
		if (pending_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= SHOWN_ERRORS)
				$display("%0t: result with no request waiting: %s", $realtime, report_text(got));
		end else begin
			want = pending_reports.pop_front();
			bad = (rsp_ch.status !== want.status)
				|| (rsp_ch.released_count !== want.released)
				|| (rsp_ch.in_flight_bytes !== want.in_flight)
				|| (rsp_ch.timer_running !== want.timer_running)
				|| (rsp_ch.timer_started !== want.timer_started)
				|| (rsp_ch.head_valid !== want.head_valid)
				|| (rsp_ch.head_len !== want.head_len)
				|| (rsp_ch.head_buffer !== want.head_buffer)
				|| (rsp_ch.entry_count !== want.entry_count);
			if (bad) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
						report_text(want), report_text(got));
			end
		end
	endtask

	// result side: random back-pressure, check on every accepted result
	initial begin : result_side
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				check_report();
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
		end
	end

	// request side: reset, directed table, then random traffic
	initial begin : request_side
		plan_row_t                 plan [24];
		seg_req_t                  rq;
		logic [trq_pkg::SEQ_W-1:0] sz;
		logic [trq_pkg::SEQ_W-1:0] hs;
		int unsigned               pick;
		int unsigned               push_pct;
		rd_idx = 0;
		wr_idx = 0;
		used = 0;
		flight = '0;
		rtx_on = 1'b0;
		calm = 1'b0;
		mismatches = 0;
		results_seen = 0;
		push_reqs = 0;
		ack_reqs = 0;
		widest_release = 0;
		foreach (status_hits[i])
			status_hits[i] = 0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.command <= trq_pkg::CMD_PUSH;
		req_ch.seg_start <= '0;
		req_ch.seg_end <= '0;
		req_ch.seg_data_len <= '0;
		req_ch.buffer_handle <= '0;
		req_ch.ack_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = '{
			// ack on an empty queue right after reset
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'd0}, 1, 1'b1,
				EMPTY_RSP},
			// first push starts the timer
			'{'{trq_pkg::CMD_PUSH, 32'd0, 32'd100, 16'h0000, 16'h0000, 32'd0}, 1, 1'b1,
				'{trq_pkg::ST_PUSHED, 5'd0, 32'd100, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000,
				5'd1}},
			// gap in sequence space
			'{'{trq_pkg::CMD_PUSH, 32'd50, 32'd150, 16'h0005, 16'h0005, 32'd0}, 1, 1'b1,
				'{trq_pkg::ST_NONCONTIG, 5'd0, 32'd100, 1'b1, 1'b0, 1'b1, 16'h0000,
				16'h0000, 5'd1}},
			'{'{trq_pkg::CMD_PUSH, 32'd100, 32'd200, 16'hffff, 16'hffff, 32'd0}, 1, 1'b0,
				NO_CHECK},
			// ack at head start, then partial and full release
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'd0}, 1, 1'b0,
				NO_CHECK},
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'd150}, 1, 1'b0,
				NO_CHECK},
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'd200}, 1, 1'b0,
				NO_CHECK},
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'hffff_ffff}, 1, 1'b1,
				EMPTY_RSP},
			// old ack
			'{'{trq_pkg::CMD_PUSH, 32'd1000, 32'd2000, 16'd1000, 16'h1234, 32'd0}, 1, 1'b0,
				NO_CHECK},
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'd999}, 1, 1'b0,
				NO_CHECK},
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'd2000}, 1, 1'b0,
				NO_CHECK},
			// ack at head start still drops a zero-size segment
			'{'{trq_pkg::CMD_PUSH, 32'd3000, 32'd3000, 16'h0000, 16'h0007, 32'd0}, 1, 1'b0,
				NO_CHECK},
			'{'{trq_pkg::CMD_PUSH, 32'd3000, 32'd3010, 16'd10, 16'h0008, 32'd0}, 1, 1'b0,
				NO_CHECK},
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'd3000}, 1, 1'b0,
				NO_CHECK},
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'd3010}, 1, 1'b0,
				NO_CHECK},
			// segment ends below its start, sizes wrap
			'{'{trq_pkg::CMD_PUSH, 32'hffff_fff0, 32'h10, 16'd32, 16'h0009, 32'd0}, 1, 1'b0,
				NO_CHECK},
			'{'{trq_pkg::CMD_PUSH, 32'h10, 32'h0, 16'h0000, 16'h000a, 32'd0}, 1, 1'b0,
				NO_CHECK},
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'hffff_ffff}, 1, 1'b0,
				NO_CHECK},
			// fill the ring, then push into a full queue
			'{'{trq_pkg::CMD_PUSH, 32'h1_0000, 32'h1_0100, 16'h0100, 16'h0100, 32'd0},
				QDEPTH, 1'b0, NO_CHECK},
			'{'{trq_pkg::CMD_PUSH, 32'h1_1000, 32'h1_1100, 16'h0001, 16'h0001, 32'd0}, 1,
				1'b1, FULL_RSP},
			// full is reported ahead of a gap
			'{'{trq_pkg::CMD_PUSH, 32'h5, 32'h6, 16'h0001, 16'h0001, 32'd0}, 1, 1'b1,
				FULL_RSP},
			// one ack drains the whole ring
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'hffff_ffff}, 1, 1'b1,
				'{trq_pkg::ST_ACK_OK, 5'd16, 32'd0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000,
				5'd0}},
			// top of sequence space
			'{'{trq_pkg::CMD_PUSH, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 32'd0},
				1, 1'b1,
				'{trq_pkg::ST_PUSHED, 5'd0, 32'd0, 1'b1, 1'b1, 1'b1, 16'hffff, 16'hffff,
				5'd1}},
			'{'{trq_pkg::CMD_ACK, 32'd0, 32'd0, 16'h0000, 16'h0000, 32'hffff_ffff}, 1, 1'b1,
				'{trq_pkg::ST_ACK_AT_HEAD, 5'd1, 32'd0, 1'b0, 1'b0, 1'b0, 16'h0000,
				16'h0000, 5'd0}}
		};

		// directed table
		foreach (plan[i]) begin
			sz = plan[i].rq.seg_end - plan[i].rq.seg_start;
			for (int k = 0; k < plan[i].reps; k++) begin
				rq = plan[i].rq;
				rq.seg_start = plan[i].rq.seg_start + 32'(k) * sz;
				rq.seg_end = rq.seg_start + sz;
				rq.buffer_handle = plan[i].rq.buffer_handle + 16'(k);
				issue(rq, plan[i].typed, plan[i].want);
			end
		end

		// random traffic, mostly well-formed segment streams and matching acks
		push_pct = 60;
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % 100 == 0) begin
				pick = $urandom_range(0, 3);
				push_pct = (pick == 0) ? 35 : (pick == 1) ? 55 : (pick == 2) ? 75 : 90;
			end
			calm = (i >= 400 && i < 550);
			rq.seg_data_len = 16'($urandom);
			rq.buffer_handle = 16'($urandom);
			rq.ack_value = $urandom;
			rq.seg_start = $urandom;
			rq.seg_end = $urandom;
			if ($urandom_range(0, 99) < push_pct) begin
				rq.command = trq_pkg::CMD_PUSH;
				pick = $urandom_range(0, 99);
				// contiguous start, a near miss, or anywhere
				if (pick < 75 && used > 0)
					rq.seg_start = sq_end[(wr_idx + QDEPTH - 1) % QDEPTH];
				else if (pick >= 85 && used > 0)
					rq.seg_start = sq_end[(wr_idx + QDEPTH - 1) % QDEPTH]
						^ (32'd1 << $urandom_range(0, 31));
				pick = $urandom_range(0, 99);
				if (pick < 65)
					sz = $urandom_range(1, 1500);
				else if (pick < 75)
					sz = '0;
				else if (pick < 85)
					sz = $urandom;
				else
					sz = $urandom_range(1, 65535);
				rq.seg_end = rq.seg_start + sz;
			end else begin
				rq.command = trq_pkg::CMD_ACK;
				if (used > 0) begin
					hs = sq_start[rd_idx];
					pick = $urandom_range(0, 99);
					if (pick < 40)
						rq.ack_value = sq_end[(rd_idx + $urandom_range(0, used - 1)) % QDEPTH];
					else if (pick < 55)
						rq.ack_value = hs;
					else if (pick < 70)
						rq.ack_value = hs + $urandom_range(0, 3000);
					else if (pick < 80)
						rq.ack_value = (hs == 0) ? hs : $urandom_range(hs - 1, 0);
					else if (pick < 90)
						rq.ack_value = '1;
				end
			end
			issue(rq, 1'b0, NO_CHECK);
		end
		req_ch.valid <= 1'b0;
		calm = 1'b0;

		// drain, then allow for a full release
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (3 + 2 * QDEPTH + 8) @(posedge clk);

		$display("covered %0d requests (%0d pushes, %0d acks), %0d results checked",
			push_reqs + ack_reqs, push_reqs, ack_reqs, results_seen);
		$display({"pushed %0d, full %0d, gap %0d, ack %0d, at head %0d, old %0d, empty %0d,",
			" widest release %0d, mismatches %0d"},
			status_hits[trq_pkg::ST_PUSHED], status_hits[trq_pkg::ST_FULL],
			status_hits[trq_pkg::ST_NONCONTIG], status_hits[trq_pkg::ST_ACK_OK],
			status_hits[trq_pkg::ST_ACK_AT_HEAD], status_hits[trq_pkg::ST_OLD_ACK],
			status_hits[trq_pkg::ST_EMPTY], widest_release, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#5000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
